FILE: rtl/swd_pkg.sv
// shared types, widths and arithmetic constants of the stopwatch display formatter
package swd_pkg;

	localparam int SEC_W   = 32;
	localparam int HUND_W  = 7;
	localparam int CFG_W   = 6;
	localparam int MARK_W  = 6;
	localparam int DIGIT_W = 4;
	localparam int OP_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 2'd0,
		OP_LAP     = 2'd1,
		OP_RESTORE = 2'd2
	} opcode_t;

	localparam logic [CFG_W-1:0]  FINE_SAVE_RESET = 6'd4;
	localparam logic [HUND_W-1:0] HUND_LAST       = 7'd99;
	localparam int                UNIT_BASE       = 60;
	localparam int                DEC_BASE        = 10;

	// 86400 = 128 * 675, quotient by 675 via reciprocal, exact for 25-bit operands
	localparam int               DAY_SHIFT       = 7;
	localparam int               DAY_X_W         = SEC_W - DAY_SHIFT;
	localparam int               DAYS_W          = 16;
	localparam int               DAY_ODD         = 675;
	localparam logic [25:0]      DAY_RECIP       = 26'd50903317;
	localparam int               DAY_RECIP_SHIFT = 35;
	localparam int               DAY_W           = 17;
	localparam int               DAY_REM_W       = 10;

	// minutes of day: (day >> 2) / 15
	localparam logic [15:0]      MIN_RECIP       = 16'd34953;
	localparam int               MIN_RECIP_SHIFT = 19;
	localparam int               MT_W            = 11;

	// hours: (minutes >> 2) / 15
	localparam logic [9:0]       HR_RECIP        = 10'd547;
	localparam int               HR_RECIP_SHIFT  = 13;
	localparam int               HR_W            = 5;

	// tens of a value below 100
	localparam logic [7:0]       DEC_RECIP       = 8'd205;
	localparam int               DEC_RECIP_SHIFT = 11;

	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [HUND_W-1:0] hund;
	} tally_t;

endpackage

FILE: rtl/swd_if.sv
// valid/ready channel interfaces for the command and display items

interface swd_cmd_if import swd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [SEC_W-1:0]  restore_seconds;

	modport source (output valid, output opcode, output restore_seconds, input ready);
	modport sink   (input valid, input opcode, input restore_seconds, output ready);
endinterface

interface swd_disp_if import swd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit_first;
	logic [DIGIT_W-1:0] digit_second;
	logic [DIGIT_W-1:0] digit_third;
	logic [DIGIT_W-1:0] digit_fourth;
	logic               blink_dot;
	logic               save_request;
	logic [SEC_W-1:0]   save_seconds;

	modport source (output valid, output digit_first, output digit_second,
		output digit_third, output digit_fourth, output blink_dot,
		output save_request, output save_seconds, input ready);
	modport sink   (input valid, input digit_first, input digit_second,
		input digit_third, input digit_fourth, input blink_dot,
		input save_request, input save_seconds, output ready);
endinterface

FILE: rtl/stopwatch_display_formatter.sv
// stopwatch with time-of-day split, save marks and four-digit display formatting
// an accepted command item passes through stage registers s1 to s7 to its display item
// throughput: one item per cycle; the counters update in the accept cycle and
// the day/minute/hour split runs down a 7-stage reciprocal-multiply pipeline
// a stalled display item freezes the whole pipeline and drops cmd.ready
// reset: async, clears counters, save mark, stage valids; fine_save_minutes = 4
module stopwatch_display_formatter import swd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	swd_cmd_if.sink          cmd,
	swd_disp_if.source       disp
);

	// architectural state
	logic [HUND_W-1:0] hund_q;
	logic [SEC_W-1:0]  sec_q;
	logic [MARK_W-1:0] mark_q;
	logic [CFG_W-1:0]  fine_q;

	// stage valids
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// stage payloads
	tally_t              tally_s1, tally_s2, tally_s3, tally_s4, tally_s5, tally_s6;
	logic [DAYS_W-1:0]   days_s2;
	logic [DAY_W-1:0]    day_s3, day_s4;
	logic [MT_W-1:0]     mt_s4, mt_s5;
	logic [MARK_W-1:0]   secs_s5;
	logic [HR_W-1:0]     hrs_s5;
	logic [HUND_W-1:0]   hi_s6, lo_s6;
	logic                save_s6;
	logic [DIGIT_W-1:0]  d1_s7, d2_s7, d3_s7, d4_s7;
	logic                blink_s7, save_s7;
	logic [SEC_W-1:0]    sec_s7;

	logic   adv, acc;
	tally_t tally_nxt;

	// whole pipe moves together; a waiting display item holds everything
	assign adv       = !vld_s7 || disp.ready;
	assign cmd.ready = adv;
	assign acc       = cmd.valid && adv;

	// counter update for the incoming command
	always_comb begin
		tally_nxt.sec  = sec_q;
		tally_nxt.hund = hund_q;
		case (opcode_t'(cmd.opcode))
			OP_TICK: begin
				if (hund_q == HUND_LAST) begin
					tally_nxt.hund = '0;
					tally_nxt.sec  = sec_q + SEC_W'(1);
				end else begin
					tally_nxt.hund = hund_q + HUND_W'(1);
				end
			end
			OP_LAP: begin
				tally_nxt.hund = '0;
				tally_nxt.sec  = '0;
			end
			OP_RESTORE: begin
				tally_nxt.sec = cmd.restore_seconds;
			end
			default: begin
			end
		endcase
	end

	// s2: whole days = (sec >> 7) / 675 by reciprocal multiply
	logic [DAY_X_W-1:0]           day_x;
	logic [DAY_X_W+25:0]          day_prod;
	assign day_x    = tally_s1.sec[SEC_W-1:DAY_SHIFT];
	assign day_prod = (DAY_X_W+26)'(day_x) * (DAY_X_W+26)'(DAY_RECIP);

	// s3: seconds of the day
	logic [DAY_X_W:0] days_odd, rem_full;
	assign days_odd = (DAY_X_W+1)'(days_s2) * (DAY_X_W+1)'(DAY_ODD);
	assign rem_full = (DAY_X_W+1)'(tally_s2.sec[SEC_W-1:DAY_SHIFT]) - days_odd;

	// s4: minutes of the day = (day >> 2) / 15
	logic [31:0] min_prod;
	assign min_prod = 32'(day_s3[DAY_W-1:2]) * 32'(MIN_RECIP);

	// s5: seconds and hours
	logic [DAY_W-1:0] mt_scaled, sec_diff;
	logic [19:0]      hr_prod;
	assign mt_scaled = DAY_W'(mt_s4) * DAY_W'(UNIT_BASE);
	assign sec_diff  = day_s4 - mt_scaled;
	assign hr_prod   = 20'(mt_s4[MT_W-1:2]) * 20'(HR_RECIP);

	// s6: minutes, save mark and upper/lower unit choice
	logic [MT_W-1:0]   mins_full;
	logic [MARK_W-1:0] mins;
	logic              fine_mode;
	logic [MARK_W-1:0] mark;
	logic [HUND_W-1:0] hi_sel, lo_sel;
	always_comb begin
		mins_full = mt_s5 - MT_W'(hrs_s5) * MT_W'(UNIT_BASE);
		mins      = mins_full[MARK_W-1:0];
		fine_mode = (hrs_s5 == '0) && (mins < fine_q);
		mark      = fine_mode ? secs_s5 : mins;
		if (hrs_s5 == '0) begin
			if (mins == '0) begin
				// ss.hh
				hi_sel = HUND_W'(secs_s5);
				lo_sel = tally_s5.hund;
			end else begin
				// mm:ss
				hi_sel = HUND_W'(mins);
				lo_sel = HUND_W'(secs_s5);
			end
		end else begin
			// hh:mm
			hi_sel = HUND_W'(hrs_s5);
			lo_sel = HUND_W'(mins);
		end
	end

	// s7: decimal split of both units
	function automatic logic [DIGIT_W-1:0] tens_of(input logic [HUND_W-1:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'(DEC_RECIP);
		return p[DEC_RECIP_SHIFT +: DIGIT_W];
	endfunction

	function automatic logic [DIGIT_W-1:0] ones_of(input logic [HUND_W-1:0] v);
		logic [HUND_W-1:0] r;
		r = v - HUND_W'(tens_of(v)) * HUND_W'(DEC_BASE);
		return r[DIGIT_W-1:0];
	endfunction

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hund_q <= '0;
			sec_q  <= '0;
			mark_q <= '0;
			fine_q <= FINE_SAVE_RESET;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (cfg_we) begin
				fine_q <= cfg_wdata;
			end
			if (acc) begin
				hund_q <= tally_nxt.hund;
				sec_q  <= tally_nxt.sec;
			end
			// marks are compared in item order as they leave s5
			if (adv && vld_s5) begin
				mark_q <= mark;
			end
			if (adv) begin
				vld_s1 <= acc;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
				vld_s6 <= vld_s5;
				vld_s7 <= vld_s6;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			tally_s1 <= tally_nxt;

			tally_s2 <= tally_s1;
			days_s2  <= day_prod[DAY_RECIP_SHIFT +: DAYS_W];

			tally_s3 <= tally_s2;
			day_s3   <= {rem_full[DAY_REM_W-1:0], tally_s2.sec[DAY_SHIFT-1:0]};

			tally_s4 <= tally_s3;
			day_s4   <= day_s3;
			mt_s4    <= min_prod[MIN_RECIP_SHIFT +: MT_W];

			tally_s5 <= tally_s4;
			mt_s5    <= mt_s4;
			secs_s5  <= sec_diff[MARK_W-1:0];
			hrs_s5   <= hr_prod[HR_RECIP_SHIFT +: HR_W];

			tally_s6 <= tally_s5;
			hi_s6    <= hi_sel;
			lo_s6    <= lo_sel;
			save_s6  <= (mark != mark_q);

			d1_s7    <= tens_of(hi_s6);
			d2_s7    <= ones_of(hi_s6);
			d3_s7    <= tens_of(lo_s6);
			d4_s7    <= ones_of(lo_s6);
			blink_s7 <= (tally_s6.hund < HUND_W'(DEC_BASE));
			save_s7  <= save_s6;
			sec_s7   <= tally_s6.sec;
		end
	end

	assign disp.valid        = vld_s7;
	assign disp.digit_first  = d1_s7;
	assign disp.digit_second = d2_s7;
	assign disp.digit_third  = d3_s7;
	assign disp.digit_fourth = d4_s7;
	assign disp.blink_dot    = blink_s7;
	assign disp.save_request = save_s7;
	assign disp.save_seconds = sec_s7;

	// checks
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready == (!disp.valid || disp.ready))
		else $error("ready does not follow output stall");

	a_hund_range: assert property (@(posedge clk) disable iff (!arst_n)
		hund_q <= HUND_LAST)
		else $error("hundredths out of range");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q < MARK_W'(UNIT_BASE))
		else $error("save mark out of range");

	a_lap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.opcode == OP_LAP) |=> (sec_q == '0 && hund_q == '0))
		else $error("lap did not clear elapsed time");

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid |-> (d1_s7 <= DIGIT_W'(9) && d2_s7 <= DIGIT_W'(9)
			&& d3_s7 <= DIGIT_W'(9) && d4_s7 <= DIGIT_W'(9)))
		else $error("display digit not decimal");

endmodule
